/* rtl/core/lfts_pkg.sv */
// Shared types, class codes and register indexes of the line-follow turn and speed shaper.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package lfts_pkg;

	// Widths of the item fields and of the internal arithmetic.
	localparam int unsigned ClassW = 4;
	localparam int unsigned TurnW  = 9;
	localparam int unsigned SpeedW = 10;
	localparam int unsigned WideW  = 11;
	localparam int unsigned StepW  = 8;
	localparam int unsigned CountW = 4;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 50;

	// Track class codes.
	localparam logic [ClassW-1:0] ClsStraight   = 4'd0;
	localparam logic [ClassW-1:0] ClsLeftSmall  = 4'd1;
	localparam logic [ClassW-1:0] ClsRightSmall = 4'd2;
	localparam logic [ClassW-1:0] ClsLeftRa0    = 4'd3;
	localparam logic [ClassW-1:0] ClsLeftRa1    = 4'd4;
	localparam logic [ClassW-1:0] ClsRightRa0   = 4'd5;
	localparam logic [ClassW-1:0] ClsRightRa1   = 4'd6;
	localparam logic [ClassW-1:0] ClsLeftBig    = 4'd7;
	localparam logic [ClassW-1:0] ClsRightBig   = 4'd8;
	localparam logic [ClassW-1:0] ClsCross      = 4'd9;
	localparam logic [ClassW-1:0] ClsLost       = 4'd10;
	localparam logic [ClassW-1:0] ClsUndef      = 4'd11;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] RegTurnAngles    = 3'd0;
	localparam logic [CfgIdxW-1:0] RegTargetSpeeds  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegRiseStep      = 3'd2;
	localparam logic [CfgIdxW-1:0] RegFallStep      = 3'd3;
	localparam logic [CfgIdxW-1:0] RegAttackStep    = 3'd4;
	localparam logic [CfgIdxW-1:0] RegReleaseStep   = 3'd5;
	localparam logic [CfgIdxW-1:0] RegCenterConfirm = 3'd6;
	localparam logic [CfgIdxW-1:0] RegTurnConfirm   = 3'd7;

	// Reset values of the configuration registers.
	localparam logic [31:0]         TurnAnglesRst   = 32'h5041_280F;
	localparam logic [CfgDataW-1:0] TargetSpeedsRst = 50'd220251659034000;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [31:0]         turn_angles;
		logic [CfgDataW-1:0] target_speeds;
		logic [StepW-1:0]    rise_step;
		logic [StepW-1:0]    fall_step;
		logic [StepW-1:0]    attack_step;
		logic [StepW-1:0]    release_step;
		logic [CountW-1:0]   center_confirm;
		logic [CountW-1:0]   turn_confirm;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/core/lfts_cfg.sv */
// Configuration register file of the line-follow turn and speed shaper.
// Depends on lfts_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module lfts_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [lfts_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [lfts_pkg::CfgDataW-1:0]    cfg_wdata,
	output lfts_pkg::cfg_t                        cfg
);

	lfts_pkg::cfg_t cfg_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turn_angles    <= lfts_pkg::TurnAnglesRst;
			cfg_q.target_speeds  <= lfts_pkg::TargetSpeedsRst;
			cfg_q.rise_step      <= 8'd5;
			cfg_q.fall_step      <= 8'd10;
			cfg_q.attack_step    <= 8'd20;
			cfg_q.release_step   <= 8'd10;
			cfg_q.center_confirm <= 4'd3;
			cfg_q.turn_confirm   <= 4'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lfts_pkg::RegTurnAngles:    cfg_q.turn_angles    <= cfg_wdata[31:0];
				lfts_pkg::RegTargetSpeeds:  cfg_q.target_speeds  <= cfg_wdata;
				lfts_pkg::RegRiseStep:      cfg_q.rise_step      <= cfg_wdata[7:0];
				lfts_pkg::RegFallStep:      cfg_q.fall_step      <= cfg_wdata[7:0];
				lfts_pkg::RegAttackStep:    cfg_q.attack_step    <= cfg_wdata[7:0];
				lfts_pkg::RegReleaseStep:   cfg_q.release_step   <= cfg_wdata[7:0];
				lfts_pkg::RegCenterConfirm: cfg_q.center_confirm <= cfg_wdata[3:0];
				lfts_pkg::RegTurnConfirm:   cfg_q.turn_confirm   <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/lfts_turn.sv */
// Turn path: class to raw turn target, confirmation filter and slew limiter.
// Depends on lfts_pkg for class codes, widths and cfg_t.
`default_nettype none

module lfts_turn (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic [lfts_pkg::ClassW-1:0]    cls,
	input  wire lfts_pkg::cfg_t                 cfg,
	output logic signed [lfts_pkg::TurnW-1:0]   turn
);

	logic signed [lfts_pkg::TurnW-1:0]  acc_q, cand_q, cur_q;
	logic [lfts_pkg::CountW-1:0]        cnt_q;
	logic [lfts_pkg::ClassW-1:0]        last_q;

	logic signed [lfts_pkg::TurnW-1:0]  a_min, a_mid, a_max, a_ra;
	logic signed [lfts_pkg::TurnW-1:0]  raw;
	logic signed [lfts_pkg::TurnW-1:0]  acc_n, cand_n;
	logic [lfts_pkg::CountW-1:0]        cnt_n, cnt_t;
	logic [lfts_pkg::TurnW-1:0]         abs_raw, abs_acc;
	logic                               same;
	logic signed [lfts_pkg::WideW-1:0]  cur_w, acc_w, step_w, rel_w, abs_cur_w, abs_accn_w;
	logic signed [lfts_pkg::WideW-1:0]  next_w;

	assign a_min = $signed({1'b0, cfg.turn_angles[7:0]});
	assign a_mid = $signed({1'b0, cfg.turn_angles[15:8]});
	assign a_max = $signed({1'b0, cfg.turn_angles[23:16]});
	assign a_ra  = $signed({1'b0, cfg.turn_angles[31:24]});

	// Raw turn target; a lost line continues the last small (at the mid angle) or big curve, else keeps the accepted turn.
	always_comb begin
		unique case (cls) inside
			lfts_pkg::ClsLeftSmall:  raw = a_min;
			lfts_pkg::ClsRightSmall: raw = -a_min;
			lfts_pkg::ClsLeftRa0, lfts_pkg::ClsLeftRa1:   raw = a_ra;
			lfts_pkg::ClsRightRa0, lfts_pkg::ClsRightRa1: raw = -a_ra;
			lfts_pkg::ClsLeftBig:    raw = a_max;
			lfts_pkg::ClsRightBig:   raw = -a_max;
			lfts_pkg::ClsLost: begin
				unique case (last_q) inside
					lfts_pkg::ClsLeftSmall:  raw = a_mid;
					lfts_pkg::ClsRightSmall: raw = -a_mid;
					lfts_pkg::ClsLeftBig:    raw = a_max;
					lfts_pkg::ClsRightBig:   raw = -a_max;
					default:                 raw = acc_q;
				endcase
			end
			default: raw = '0;
		endcase
	end

	// Confirmation filter: turns from zero and stronger same-direction turns pass at once.
	always_comb begin
		abs_raw = raw[lfts_pkg::TurnW-1] ? lfts_pkg::TurnW'(-raw) : lfts_pkg::TurnW'(raw);
		abs_acc = acc_q[lfts_pkg::TurnW-1] ? lfts_pkg::TurnW'(-acc_q) : lfts_pkg::TurnW'(acc_q);
		same = ((acc_q > 0) && (raw > 0)) || ((acc_q < 0) && (raw < 0));
		acc_n  = acc_q;
		cand_n = cand_q;
		cnt_n  = cnt_q;
		cnt_t  = cnt_q;
		if (raw == acc_q) begin
			cand_n = raw;
			cnt_n  = '0;
		end else if (((acc_q == 0) && (raw != 0)) || (same && (abs_raw > abs_acc))) begin
			acc_n  = raw;
			cand_n = raw;
			cnt_n  = '0;
		end else begin
			if (raw == cand_q) begin
				cnt_t = (cnt_q < cfg.turn_confirm) ? cnt_q + 1'b1 : cnt_q;
			end else begin
				cand_n = raw;
				cnt_t  = lfts_pkg::CountW'(1);
			end
			if (cnt_t >= cfg.turn_confirm) begin
				acc_n = raw;
				cnt_n = '0;
			end else begin
				cnt_n = cnt_t;
			end
		end
	end

	// Slew limiter toward the accepted turn, through zero on reversal.
	always_comb begin
		cur_w = lfts_pkg::WideW'(cur_q);
		acc_w = lfts_pkg::WideW'(acc_n);
		rel_w = $signed({3'b000, cfg.release_step});
		abs_cur_w  = cur_w[lfts_pkg::WideW-1] ? -cur_w : cur_w;
		abs_accn_w = acc_w[lfts_pkg::WideW-1] ? -acc_w : acc_w;
		step_w = (abs_accn_w > abs_cur_w) ? $signed({3'b000, cfg.attack_step}) : rel_w;
		if (cur_w == acc_w) begin
			next_w = cur_w;
		end else if (((cur_w > 0) && (acc_w < 0)) || ((cur_w < 0) && (acc_w > 0))) begin
			if (abs_cur_w <= rel_w) begin
				next_w = '0;
			end else begin
				next_w = (cur_w > 0) ? cur_w - rel_w : cur_w + rel_w;
			end
		end else if (acc_w > cur_w + step_w) begin
			next_w = cur_w + step_w;
		end else if (acc_w < cur_w - step_w) begin
			next_w = cur_w - step_w;
		end else begin
			next_w = acc_w;
		end
	end

	// Turn state registers, advanced once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cand_q <= '0;
			cnt_q  <= '0;
			cur_q  <= '0;
			last_q <= lfts_pkg::ClsUndef;
		end else if (en) begin
			acc_q  <= acc_n;
			cand_q <= cand_n;
			cnt_q  <= cnt_n;
			cur_q  <= next_w[lfts_pkg::TurnW-1:0];
			if (cls != lfts_pkg::ClsLost) begin
				last_q <= cls;
			end
		end
	end

	assign turn = cur_q;

endmodule

`default_nettype wire

/* rtl/core/lfts_speed.sv */
// Speed path: hysteretic speed class, target lookup and rise/fall ramp.
// Depends on lfts_pkg for class codes, widths and cfg_t.
`default_nettype none

module lfts_speed (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic [lfts_pkg::ClassW-1:0]   cls,
	input  wire lfts_pkg::cfg_t                cfg,
	output logic [lfts_pkg::SpeedW-1:0]        speed
);

	logic [lfts_pkg::ClassW-1:0]  sc_q, sc_n;
	logic [lfts_pkg::CountW-1:0]  cc_q, cc_n;
	logic [lfts_pkg::SpeedW-1:0]  spd_q, tgt;
	logic [lfts_pkg::WideW-1:0]   cur_w, tgt_w, rise_w, fall_w, next_w;

	// Speed class follows any turn at once, returns to straight after confirmation.
	always_comb begin
		sc_n = sc_q;
		cc_n = cc_q;
		if (cls == lfts_pkg::ClsStraight) begin
			if (sc_q != lfts_pkg::ClsStraight) begin
				cc_n = (cc_q < cfg.center_confirm) ? cc_q + 1'b1 : cc_q;
				if (cc_n >= cfg.center_confirm) begin
					sc_n = lfts_pkg::ClsStraight;
				end
			end
		end else begin
			cc_n = '0;
			sc_n = cls;
		end
	end

	// Target speed for the new class.
	always_comb begin
		unique case (sc_n) inside
			lfts_pkg::ClsStraight: tgt = cfg.target_speeds[9:0];
			lfts_pkg::ClsLeftSmall, lfts_pkg::ClsRightSmall: tgt = cfg.target_speeds[19:10];
			lfts_pkg::ClsLeftRa0, lfts_pkg::ClsLeftRa1,
			lfts_pkg::ClsRightRa0, lfts_pkg::ClsRightRa1: tgt = cfg.target_speeds[29:20];
			lfts_pkg::ClsLeftBig, lfts_pkg::ClsRightBig,
			lfts_pkg::ClsCross: tgt = cfg.target_speeds[39:30];
			default: tgt = cfg.target_speeds[49:40];
		endcase
	end

	// Ramp toward the target with separate rise and fall limits.
	always_comb begin
		cur_w  = {1'b0, spd_q};
		tgt_w  = {1'b0, tgt};
		rise_w = {3'b000, cfg.rise_step};
		fall_w = {3'b000, cfg.fall_step};
		if (tgt_w > cur_w) begin
			next_w = (tgt_w - cur_w <= rise_w) ? tgt_w : cur_w + rise_w;
		end else begin
			next_w = (cur_w - tgt_w <= fall_w) ? tgt_w : cur_w - fall_w;
		end
	end

	// Speed state registers, advanced once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q  <= lfts_pkg::ClsStraight;
			cc_q  <= '0;
			spd_q <= '0;
		end else if (en) begin
			sc_q  <= sc_n;
			cc_q  <= cc_n;
			spd_q <= next_w[lfts_pkg::SpeedW-1:0];
		end
	end

	assign speed = spd_q;

endmodule

`default_nettype wire

/* rtl/core/line_follow_turn_speed_shaper_top.sv */
// Top level of the line-follow turn and speed shaper: input stage, handshake and result register.
// Depends on lfts_pkg, lfts_cfg, lfts_turn and lfts_speed.
`default_nettype none

// Each input item carries one classified line-sensor state and yields exactly one result item
// with the slew-limited turn command and the ramped speed command. An accepted item is held in
// the input register and then evaluated into the turn and speed state registers, which also
// drive the output; the result is offered once the item has passed the input register and the
// state registers, and one item is taken every cycle as long as results are taken.
// Configuration writes take effect on the next cycle and are meant for idle periods only.
module line_follow_turn_speed_shaper_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,   // [3:0] track_class, [7:4] zero
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [23:0]                          m_tdata,   // [8:0] turn_command, [18:9] speed_command
	input  wire logic                            cfg_we,
	input  wire logic [lfts_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [lfts_pkg::CfgDataW-1:0]   cfg_wdata
);

	lfts_pkg::cfg_t                     cfg;
	logic                               valid_s1;
	logic [lfts_pkg::ClassW-1:0]        class_s1;
	logic                               out_valid_q;
	logic                               adv;
	logic signed [lfts_pkg::TurnW-1:0]  turn;
	logic [lfts_pkg::SpeedW-1:0]        speed;

	// The staged item moves into the state when the result slot is free or being emptied.
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			class_s1 <= s_tdata[lfts_pkg::ClassW-1:0];
		end
	end

	// Result valid; the state registers themselves hold the result payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	lfts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lfts_turn u_turn (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cls    (class_s1),
		.cfg    (cfg),
		.turn   (turn)
	);

	lfts_speed u_speed (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cls    (class_s1),
		.cfg    (cfg),
		.speed  (speed)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, speed, turn};

endmodule

`default_nettype wire
